FILE: hw/rtl/nch_pkg.sv
`timescale 1ns / 1ps

package nch_pkg;

  // Fixed field widths of the ports.
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 4;
  localparam int ELEM_W   = 7;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int DIST_W   = 40;
  localparam int CFG_W    = 5;

  localparam logic [DIST_W-1:0]  DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(16);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_DESC  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACC,
    ST_DRAIN,
    ST_SCAN,
    ST_SCAN_END,
    ST_HREAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic cnt_clr;
    logic store_wr;
    logic hist_clr;
    logic acc_issue;
    logic scan_issue;
    logic hist_rd;
    logic hist_rd_best;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic eidx_ok;
    logic load_ok;
    logic cnt_last;
    logic pipe_busy;
    logic out_busy;
  } status_t;

endpackage

FILE: hw/rtl/nch_ctrl.sv
`timescale 1ns / 1ps

module nch_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  nch_pkg::status_t  status,
  output nch_pkg::cmd_t     cmd
);

  nch_pkg::state_t state;
  nch_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      nch_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = nch_pkg::ST_DECODE;
        end
      end
      nch_pkg::ST_DECODE: begin
        cmd.cnt_clr = 1'b1;
        unique case (status.op)
          nch_pkg::OP_LOAD: begin
            cmd.store_wr = status.load_ok;
            state_next   = nch_pkg::ST_IDLE;
          end
          nch_pkg::OP_CLEAR: begin
            cmd.hist_clr = 1'b1;
            state_next   = nch_pkg::ST_IDLE;
          end
          nch_pkg::OP_READ: begin
            cmd.hist_rd = 1'b1;
            state_next  = nch_pkg::ST_EMIT;
          end
          nch_pkg::OP_DESC: begin
            priority if (status.eidx_ok) begin
              state_next = nch_pkg::ST_ACC;
            end else if (status.last) begin
              state_next = nch_pkg::ST_SCAN;
            end else begin
              state_next = nch_pkg::ST_IDLE;
            end
          end
        endcase
      end
      nch_pkg::ST_ACC: begin
        cmd.acc_issue = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = nch_pkg::ST_DRAIN;
        end
      end
      nch_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = status.last ? nch_pkg::ST_SCAN : nch_pkg::ST_IDLE;
        end
      end
      nch_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = nch_pkg::ST_SCAN_END;
        end
      end
      nch_pkg::ST_SCAN_END: begin
        state_next = nch_pkg::ST_HREAD;
      end
      nch_pkg::ST_HREAD: begin
        cmd.hist_rd      = 1'b1;
        cmd.hist_rd_best = 1'b1;
        state_next       = nch_pkg::ST_EMIT;
      end
      nch_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = nch_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/nch_datapath.sv
`timescale 1ns / 1ps

module nch_datapath #(
  parameter int MAX_CENTROIDS = 16,
  parameter int VECTOR_LENGTH = 128,
  parameter int VALUE_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nch_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [nch_pkg::OPCODE_W-1:0] opcode,
  input  logic [nch_pkg::INDEX_W-1:0]  centroid_index,
  input  logic [nch_pkg::ELEM_W-1:0]   element_index,
  input  logic [nch_pkg::VALUE_W-1:0]  element_value,
  input  logic                         descriptor_last,
  input  nch_pkg::cmd_t                cmd,
  output nch_pkg::status_t             status,
  input  logic                         result_ready,
  output logic                         result_valid,
  output logic                         result_kind,
  output logic [nch_pkg::INDEX_W-1:0]  label,
  output logic [nch_pkg::COUNT_W-1:0]  bin_count,
  output logic [nch_pkg::DIST_W-1:0]   min_distance
);

  localparam int CW    = $clog2(MAX_CENTROIDS);
  localparam int DEPTH = MAX_CENTROIDS * VECTOR_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int VB    = (VALUE_BITS < nch_pkg::VALUE_W) ? VALUE_BITS : nch_pkg::VALUE_W;
  localparam int SQ_W  = 2 * VB;
  localparam int DW    = nch_pkg::DIST_W;

  // Captured word and configuration.
  logic [nch_pkg::CFG_W-1:0]   cfg;
  nch_pkg::op_t                op_q;
  logic [nch_pkg::INDEX_W-1:0] cidx_q;
  logic [nch_pkg::ELEM_W-1:0]  eidx_q;
  logic [VB-1:0]               val_q;
  logic                        last_q;

  logic [CW-1:0] nm1;
  logic [CW-1:0] cnt;
  logic [AW-1:0] base;
  logic          eidx_ok;
  logic          cidx_ok;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] acc_addr;

  // Memories.
  logic [VB-1:0]      store_mem [DEPTH];
  logic [VB-1:0]      store_q;
  logic [DW-1:0]      rdist_mem [MAX_CENTROIDS];
  logic [MAX_CENTROIDS-1:0] rv;
  logic [DW-1:0]      rd_q;
  logic               rv_q;
  logic [nch_pkg::COUNT_W-1:0] hist_mem [MAX_CENTROIDS];
  logic [MAX_CENTROIDS-1:0] hv;
  logic [nch_pkg::COUNT_W-1:0] hist_q;
  logic               hv_q;
  logic [CW-1:0]      hist_addr;

  // Accumulate pipeline.
  logic          s1v;
  logic          scan_v1;
  logic [CW-1:0] idx1;
  logic          s2v;
  logic [SQ_W-1:0] sq;
  logic [DW-1:0] rd2;
  logic [CW-1:0] idx2;

  logic [DW-1:0]   rd_eff;
  logic [VB-1:0]   diff;
  logic [SQ_W-1:0] sq_next;
  logic [DW:0]     sum;
  logic [DW-1:0]   sum_sat;

  logic [DW-1:0] best_d;
  logic [CW-1:0] best_idx;

  logic [nch_pkg::COUNT_W-1:0] hq_eff;
  logic [nch_pkg::COUNT_W-1:0] hinc;

  always_comb begin
    int eff;
    eff = (cfg == '0) ? 1 : int'(cfg);
    if (eff > MAX_CENTROIDS) begin
      eff = MAX_CENTROIDS;
    end
    nm1 = CW'(eff - 1);
  end

  assign eidx_ok   = (32'(eidx_q) < VECTOR_LENGTH);
  assign cidx_ok   = (32'(cidx_q) < MAX_CENTROIDS);
  assign load_addr = AW'(32'(cidx_q) * VECTOR_LENGTH + 32'(eidx_q));
  assign acc_addr  = base + AW'(eidx_q);
  assign hist_addr = cmd.hist_rd_best ? best_idx : (cidx_ok ? CW'(cidx_q) : '0);

  assign rd_eff  = rv_q ? rd_q : '0;
  assign diff    = (val_q >= store_q) ? (val_q - store_q) : (store_q - val_q);
  assign sq_next = SQ_W'(diff) * SQ_W'(diff);
  assign sum     = {1'b0, rd2} + (DW + 1)'(sq);
  assign sum_sat = sum[DW] ? nch_pkg::DIST_MAX : sum[DW-1:0];

  assign hq_eff = hv_q ? hist_q : '0;
  assign hinc   = (hq_eff == nch_pkg::COUNT_MAX) ? hq_eff : hq_eff + 1'b1;

  assign status.op        = op_q;
  assign status.last      = last_q;
  assign status.eidx_ok   = eidx_ok;
  assign status.load_ok   = eidx_ok && cidx_ok;
  assign status.cnt_last  = (cnt == nm1);
  assign status.pipe_busy = s1v || s2v;
  assign status.out_busy  = result_valid && !result_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg          <= nch_pkg::CFG_RESET;
      cnt          <= '0;
      base         <= '0;
      s1v          <= 1'b0;
      scan_v1      <= 1'b0;
      s2v          <= 1'b0;
      rv           <= '0;
      hv           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg <= cfg_wdata;
      end
      if (cmd.cnt_clr) begin
        cnt  <= '0;
        base <= '0;
      end else if (cmd.acc_issue || cmd.scan_issue) begin
        cnt  <= cnt + 1'b1;
        base <= base + AW'(VECTOR_LENGTH);
      end
      s1v     <= cmd.acc_issue;
      scan_v1 <= cmd.scan_issue;
      s2v     <= s1v;
      if (cmd.emit && op_q == nch_pkg::OP_DESC) begin
        rv           <= '0;
        hv[best_idx] <= 1'b1;
      end else if (s2v) begin
        rv[idx2] <= 1'b1;
      end
      if (cmd.hist_clr) begin
        hv <= '0;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= nch_pkg::op_t'(opcode);
      cidx_q <= centroid_index;
      eidx_q <= element_index;
      val_q  <= element_value[VB-1:0];
      last_q <= descriptor_last;
    end
    idx1 <= cnt;
    sq   <= sq_next;
    rd2  <= rd_eff;
    idx2 <= idx1;
    if (scan_v1 && (idx1 == '0 || rd_eff < best_d)) begin
      best_d   <= rd_eff;
      best_idx <= idx1;
    end
    if (cmd.emit) begin
      if (op_q == nch_pkg::OP_DESC) begin
        result_kind  <= 1'b0;
        label        <= nch_pkg::INDEX_W'(32'(best_idx));
        bin_count    <= hinc;
        min_distance <= best_d;
      end else begin
        result_kind  <= 1'b1;
        label        <= cidx_q;
        bin_count    <= cidx_ok ? hq_eff : '0;
        min_distance <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store_mem[load_addr] <= val_q;
    end
    if (cmd.acc_issue) begin
      store_q <= store_mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s2v) begin
      rdist_mem[idx2] <= sum_sat;
    end
    if (cmd.acc_issue || cmd.scan_issue) begin
      rd_q <= rdist_mem[cnt];
      rv_q <= rv[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && op_q == nch_pkg::OP_DESC) begin
      hist_mem[best_idx] <= hinc;
    end
    if (cmd.hist_rd) begin
      hist_q <= hist_mem[hist_addr];
      hv_q   <= hv[hist_addr];
    end
  end

endmodule

FILE: hw/rtl/nearest_centroid_histogram_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Word
// item      in         item_valid / item_ready      opcode, centroid_index, element_index,
//                                                   element_value, descriptor_last
// result    out        result_valid / result_ready  result_kind, label, bin_count,
//                                                   min_distance
// config    in         cfg_we (no wait)             cfg_wdata (centroids_in_use)
//
// A load or clear word is captured and then decoded. For a descriptor element, n being the
// number of active centroids, the one shared subtract-square-accumulate unit handles one
// centroid per cycle, with a centroid store read and a running distance read in each; the
// pipeline then drains. A final element adds the minimum scan and the histogram update.
// A bin read fetches its bin and emits it. Reset is synchronous; valid bits clear the running
// distances and the histogram at once, so no clearing pass follows reset.
// The result register frees the item side: a new word is taken while a result waits, and
// only a second result stalls until the first is taken.

module nearest_centroid_histogram_unit #(
  parameter int MAX_CENTROIDS = 16,
  parameter int VECTOR_LENGTH = 128,
  parameter int VALUE_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nch_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [nch_pkg::OPCODE_W-1:0] opcode,
  input  logic [nch_pkg::INDEX_W-1:0]  centroid_index,
  input  logic [nch_pkg::ELEM_W-1:0]   element_index,
  input  logic [nch_pkg::VALUE_W-1:0]  element_value,
  input  logic                         descriptor_last,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         result_kind,
  output logic [nch_pkg::INDEX_W-1:0]  label,
  output logic [nch_pkg::COUNT_W-1:0]  bin_count,
  output logic [nch_pkg::DIST_W-1:0]   min_distance
);

  // The controller sequences each word; the datapath holds the stores, the shared
  // accumulate pipeline, the minimum search and the result register.
  nch_pkg::cmd_t    cmd;
  nch_pkg::status_t status;

  nch_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  nch_datapath #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .VECTOR_LENGTH (VECTOR_LENGTH),
    .VALUE_BITS    (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .opcode          (opcode),
    .centroid_index  (centroid_index),
    .element_index   (element_index),
    .element_value   (element_value),
    .descriptor_last (descriptor_last),
    .cmd             (cmd),
    .status          (status),
    .result_ready    (result_ready),
    .result_valid    (result_valid),
    .result_kind     (result_kind),
    .label           (label),
    .bin_count       (bin_count),
    .min_distance    (min_distance)
  );

endmodule

FILE: hw/rtl/nch_checker.sv
`timescale 1ns / 1ps

module nch_checker #(
  parameter int MAX_CENTROIDS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        result_kind,
  input logic [nch_pkg::INDEX_W-1:0] label,
  input logic [nch_pkg::COUNT_W-1:0] bin_count,
  input logic [nch_pkg::DIST_W-1:0]  min_distance
);

  // A stalled result holds its word.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_kind) &&
      $stable(label) && $stable(bin_count) && $stable(min_distance))
    else $error("stalled result changed");

  // A bin read carries no distance.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind |-> min_distance == '0)
    else $error("bin read with nonzero distance");

  // A classification has just bumped its bin, so the count is at least one.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_kind |-> bin_count != '0)
    else $error("classification with zero count");

  // The winning centroid lies inside the store.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_kind |-> 32'(label) < MAX_CENTROIDS)
    else $error("label beyond centroid store");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind nearest_centroid_histogram_unit nch_checker #(
  .MAX_CENTROIDS (MAX_CENTROIDS)
) u_nch_checker (.*);

FILE: bench/nch_checker.sv
`timescale 1ns / 1ps

module nch_scoreboard
  import nch_pkg::*;
#(
  parameter int MAX_CENTROIDS = 16,
  parameter int VECTOR_LENGTH = 128,
  parameter int VALUE_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                item_valid,
  input  logic                item_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [INDEX_W-1:0]  centroid_index,
  input  logic [ELEM_W-1:0]   element_index,
  input  logic [VALUE_W-1:0]  element_value,
  input  logic                descriptor_last,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic                result_kind,
  input  logic [INDEX_W-1:0]  label,
  input  logic [COUNT_W-1:0]  bin_count,
  input  logic [DIST_W-1:0]   min_distance,
  output int                  error_count,
  output int                  awaited_count,
  output int                  checked_count
);

  localparam logic [VALUE_W-1:0] VALUE_MASK = (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} :
                                              VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct {
    logic                kind;
    logic [INDEX_W-1:0]  label;
    logic [COUNT_W-1:0]  count;
    logic [DIST_W-1:0]   distance;
  } result_word_t;

  logic [VALUE_W-1:0] centroid_mem [MAX_CENTROIDS*VECTOR_LENGTH];
  logic [DIST_W-1:0]  partial_dist [MAX_CENTROIDS];
  logic [COUNT_W-1:0] bin_tally [MAX_CENTROIDS];
  logic [CFG_W-1:0]   centroid_limit;
  result_word_t       awaited_results [$];
  int                 errs = 0;
  int                 checked = 0;

  // Out-of-range register values clamp to the nearest legal count.
  function automatic int active_centroids();
    int n;
    n = int'(centroid_limit);
    if (n < 1) n = 1;
    if (n > MAX_CENTROIDS) n = MAX_CENTROIDS;
    return n;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    errs++;
    if (errs <= 40) $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic predict_word(input op_t op, input logic [INDEX_W-1:0] ci,
                              input logic [ELEM_W-1:0] ei, input logic [VALUE_W-1:0] v,
                              input logic last);
    int                   n;
    int                   best;
    logic [VALUE_W-1:0]   val;
    logic [VALUE_W-1:0]   cv;
    logic [VALUE_W-1:0]   gap;
    logic [2*VALUE_W-1:0] sq;
    logic [DIST_W:0]      sum;
    logic [DIST_W-1:0]    best_d;
    result_word_t         w;
    val = v & VALUE_MASK;
    case (op)
      OP_LOAD: begin
        if (int'(ci) < MAX_CENTROIDS && int'(ei) < VECTOR_LENGTH)
          centroid_mem[int'(ci)*VECTOR_LENGTH + int'(ei)] = val;
      end
      OP_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
      end
      OP_READ: begin
        w.kind     = 1'b1;
        w.label    = ci;
        w.count    = (int'(ci) < MAX_CENTROIDS) ? bin_tally[ci] : '0;
        w.distance = '0;
        awaited_results.insert(awaited_results.size(), w);
      end
      default: begin
        n = active_centroids();
        if (int'(ei) < VECTOR_LENGTH) begin
          for (int c = 0; c < n; c++) begin
            cv  = centroid_mem[c*VECTOR_LENGTH + int'(ei)];
            gap = (val >= cv) ? val - cv : cv - val;
            sq  = gap * gap;
            sum = partial_dist[c] + sq;
            partial_dist[c] = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
          end
        end
        if (last) begin
          best   = 0;
          best_d = partial_dist[0];
          for (int c = 1; c < n; c++) begin
            if (partial_dist[c] < best_d) begin
              best_d = partial_dist[c];
              best   = c;
            end
          end
          if (bin_tally[best] != COUNT_MAX) bin_tally[best]++;
          foreach (partial_dist[i]) partial_dist[i] = '0;
          w.kind     = 1'b0;
          w.label    = INDEX_W'(best);
          w.count    = bin_tally[best];
          w.distance = best_d;
          awaited_results.insert(awaited_results.size(), w);
        end
      end
    endcase
  endtask

  task automatic check_word();
    result_word_t w;
    checked++;
    if (awaited_results.size() == 0) begin
      errs++;
      if (errs <= 40) $display("%0t: result word with none expected (label %0h)", $time, label);
    end else begin
      w = awaited_results.pop_front();
      if (result_kind !== w.kind)      note_mismatch("result_kind", w.kind, result_kind);
      if (label !== w.label)           note_mismatch("label", w.label, label);
      if (bin_count !== w.count)       note_mismatch("bin_count", w.count, bin_count);
      if (min_distance !== w.distance) note_mismatch("min_distance", w.distance, min_distance);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      centroid_limit = CFG_RESET;
      foreach (centroid_mem[i]) centroid_mem[i] = '0;
      foreach (partial_dist[i]) partial_dist[i] = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
      awaited_results.delete();
    end else begin
      // A result can never come from the word taken at the same edge, so
      // results are matched before that word is predicted.
      if (result_valid && result_ready) check_word();
      if (cfg_we) centroid_limit = cfg_wdata;
      if (item_valid && item_ready)
        predict_word(op_t'(opcode), centroid_index, element_index, element_value,
                     descriptor_last);
    end
    error_count   <= errs;
    awaited_count <= awaited_results.size();
    checked_count <= checked;
  end

endmodule

FILE: bench/tb_nearest_centroid_histogram_unit.sv
`timescale 1ns / 1ps

module tb_nearest_centroid_histogram_unit;
  import nch_pkg::*;

  localparam int NUM_CENTROIDS = 16;
  localparam int VEC_LEN       = 128;
  // A descriptor word can keep the block busy without producing a result; this pause
  // covers the longest such stretch before any register write.
  localparam int DRAIN_CYCLES  = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [INDEX_W-1:0]  centroid_index = '0;
  logic [ELEM_W-1:0]   element_index = '0;
  logic [VALUE_W-1:0]  element_value = '0;
  logic                descriptor_last = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic                result_kind;
  logic [INDEX_W-1:0]  label;
  logic [COUNT_W-1:0]  bin_count;
  logic [DIST_W-1:0]   min_distance;

  int error_count;
  int awaited_count;
  int checked_count;

  // Receiver controls. The main sequence only writes these with nonblocking
  // assignments; the receiver process reads them at the next edge.
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  // Stimulus bookkeeping. A column is ready once all centroids hold a value at
  // that element index; descriptor words only use ready columns, so no unwritten
  // centroid element is ever read.
  int idle_pct = 0;
  int words_sent = 0;
  bit col_ready [VEC_LEN];
  int ready_cols [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nearest_centroid_histogram_unit #(
    .MAX_CENTROIDS(NUM_CENTROIDS),
    .VECTOR_LENGTH(VEC_LEN),
    .VALUE_BITS   (VALUE_W)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .opcode         (opcode),
    .centroid_index (centroid_index),
    .element_index  (element_index),
    .element_value  (element_value),
    .descriptor_last(descriptor_last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_kind    (result_kind),
    .label          (label),
    .bin_count      (bin_count),
    .min_distance   (min_distance)
  );

  nch_scoreboard #(
    .MAX_CENTROIDS(NUM_CENTROIDS),
    .VECTOR_LENGTH(VEC_LEN),
    .VALUE_BITS   (VALUE_W)
  ) u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .opcode         (opcode),
    .centroid_index (centroid_index),
    .element_index  (element_index),
    .element_value  (element_value),
    .descriptor_last(descriptor_last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_kind    (result_kind),
    .label          (label),
    .bin_count      (bin_count),
    .min_distance   (min_distance),
    .error_count    (error_count),
    .awaited_count  (awaited_count),
    .checked_count  (checked_count)
  );

  // The receiver either stalls at random or, when the main sequence toggles
  // hold_req, holds ready low for a long fixed stretch so the block backs up.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // The watchdog ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("tb_nearest_centroid_histogram_unit: done, errors");
    $finish;
  end

  // Mostly random values, with both extremes turning up often.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VALUE_W'($urandom);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_col();
    return ELEM_W'(ready_cols[$urandom_range(0, ready_cols.size() - 1)]);
  endfunction

  // Offers one item word and returns at the edge where it is taken. Valid is
  // left high so a following word can go out back to back.
  task automatic send_word(input op_t op, input logic [INDEX_W-1:0] ci,
                           input logic [ELEM_W-1:0] ei, input logic [VALUE_W-1:0] v,
                           input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid      <= 1'b1;
    opcode          <= op;
    centroid_index  <= ci;
    element_index   <= ei;
    element_value   <= v;
    descriptor_last <= last;
    do @(posedge clk); while (!item_ready);
    words_sent++;
  endtask

  // Loads one element index for every centroid and marks that column usable.
  task automatic load_column(input int e);
    for (int c = 0; c < NUM_CENTROIDS; c++)
      send_word(OP_LOAD, INDEX_W'(c), ELEM_W'(e), pick_value(), 1'($urandom));
    if (!col_ready[e]) begin
      col_ready[e] = 1'b1;
      ready_cols.insert(ready_cols.size(), e);
    end
  endtask

  // Waits until every expected result has come back, then lets the block finish
  // any descriptor word that produces no result.
  task automatic settle_block();
    item_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int sender, input int receiver);
    idle_pct = sender;
    stall_pct <= receiver;
  endtask

  initial begin : main
    int preload_cols [11] = '{0, 1, 2, 4, 8, 16, 32, 64, 127, 85, 42};
    int phase_limit [8] = '{16, 1, 7, 0, 31, 17, 0, 0};
    int phase_start;
    int pick;
    int len;
    int e;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Preload a set of columns whose indices together toggle every index bit.
    foreach (preload_cols[i]) load_column(preload_cols[i]);

    // Default register: all sixteen centroids compete. Extreme values at the
    // lowest and highest element indices, then both ends of the histogram.
    send_word(OP_DESC, INDEX_W'($urandom), 7'd0, 16'h0000, 1'b1);
    send_word(OP_DESC, INDEX_W'($urandom), 7'd127, 16'hFFFF, 1'b1);
    send_word(OP_READ, 4'd0, ELEM_W'($urandom), VALUE_W'($urandom), 1'b0);
    send_word(OP_READ, 4'd15, ELEM_W'($urandom), VALUE_W'($urandom), 1'b1);

    // Tie: centroids 1 and 2 are equally close, so the lower index must win.
    // A repeated element index then adds its term twice and centroid 0 wins.
    write_limit(4);
    send_word(OP_LOAD, 4'd0, 7'd0, 16'hFFFF, 1'b0);
    send_word(OP_LOAD, 4'd1, 7'd0, 16'd1000, 1'b0);
    send_word(OP_LOAD, 4'd2, 7'd0, 16'd1000, 1'b0);
    send_word(OP_LOAD, 4'd3, 7'd0, 16'h0000, 1'b0);
    send_word(OP_DESC, 4'd0, 7'd0, 16'd1000, 1'b1);
    send_word(OP_DESC, 4'd0, 7'd0, 16'hFFFF, 1'b0);
    send_word(OP_DESC, 4'd0, 7'd0, 16'hFFFF, 1'b1);

    // Register raised in the middle of a descriptor: the newly active centroids
    // only see the terms that arrive afterward.
    write_limit(2);
    send_word(OP_DESC, 4'd0, 7'd1, pick_value(), 1'b0);
    write_limit(5);
    send_word(OP_DESC, 4'd0, 7'd2, pick_value(), 1'b1);

    // Register values outside the legal range clamp to one and to sixteen.
    write_limit(0);
    send_word(OP_DESC, 4'd0, 7'd4, pick_value(), 1'b1);
    write_limit(31);
    send_word(OP_DESC, 4'd0, 7'd8, pick_value(), 1'b1);

    // Clear, then read a bin that must now be empty.
    send_word(OP_CLEAR, INDEX_W'($urandom), ELEM_W'($urandom), VALUE_W'($urandom), 1'b1);
    send_word(OP_READ, 4'd1, ELEM_W'($urandom), VALUE_W'($urandom), 1'b0);

    // Distance saturation: 260 maximal terms overflow 40 bits for three equal
    // centroids, which then tie at the ceiling.
    write_limit(3);
    for (int c = 0; c < 3; c++) send_word(OP_LOAD, INDEX_W'(c), 7'd0, 16'h0000, 1'b0);
    for (int k = 0; k < 260; k++) send_word(OP_DESC, 4'd0, 7'd0, 16'hFFFF, k == 259);

    // With one centroid every descriptor lands in bin 0. A clear then empties it.
    write_limit(1);
    for (int k = 0; k < 6; k++)
      send_word(OP_DESC, INDEX_W'($urandom), pick_col(), VALUE_W'($urandom), 1'b1);
    send_word(OP_READ, 4'd0, ELEM_W'($urandom), VALUE_W'($urandom), 1'b0);
    send_word(OP_CLEAR, INDEX_W'($urandom), ELEM_W'($urandom), VALUE_W'($urandom), 1'b0);
    send_word(OP_READ, 4'd0, ELEM_W'($urandom), VALUE_W'($urandom), 1'b1);

    // Back pressure: the receiver holds off while reads keep coming, so the
    // result register fills and the item side has to stall.
    write_limit(16);
    set_idling(0, 0);
    hold_req <= ~hold_req;
    for (int k = 0; k < 12; k++)
      send_word(OP_READ, INDEX_W'($urandom), ELEM_W'($urandom), VALUE_W'($urandom), 1'b0);

    // Random phases, each with its own register setting and idle pattern. Most
    // words form complete descriptors; loads, reads, clears and stray
    // descriptor words fill the rest.
    phase_limit[6] = $urandom_range(1, 16);
    phase_limit[7] = $urandom_range(0, 31);
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(phase_limit[ph]);
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(73, 0);
        2: set_idling(0, 73);
        default: set_idling(12, 12);
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < 46) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
          for (int k = 0; k < len; k++)
            send_word(OP_DESC, INDEX_W'($urandom), pick_col(), pick_value(), k == len - 1);
        end else if (pick < 78) begin
          send_word(OP_LOAD, INDEX_W'($urandom), pick_col(), pick_value(), 1'($urandom));
        end else if (pick < 81) begin
          e = $urandom_range(0, VEC_LEN - 1);
          if (!col_ready[e]) load_column(e);
        end else if (pick < 91) begin
          send_word(OP_READ, INDEX_W'($urandom), ELEM_W'($urandom), VALUE_W'($urandom),
                    1'($urandom));
        end else if (pick < 94) begin
          send_word(OP_CLEAR, INDEX_W'($urandom), ELEM_W'($urandom), VALUE_W'($urandom),
                    1'($urandom));
        end else begin
          send_word(OP_DESC, INDEX_W'($urandom), pick_col(), pick_value(), 1'($urandom));
        end
      end
    end

    set_idling(0, 0);
    settle_block();
    $display("Sent %0d item words and checked %0d result words across many register",
             words_sent, checked_count);
    $display("settings and four idle patterns, with ties, saturated distances and a long hold.");
    if (error_count == 0 && awaited_count == 0) begin
      $display("tb_nearest_centroid_histogram_unit: done, clean");
    end else begin
      $display("tb_nearest_centroid_histogram_unit: done, errors");
    end
    $finish;
  end

endmodule
